>>> sv/ldgs_pkg.sv
// ----------------------------------------------------------------------------
// ldgs_pkg
// Shared constants and types for the LED driver grayscale serializer.
// ----------------------------------------------------------------------------
package ldgs_pkg;

	localparam int WORD_BITS = 16;
	localparam int CH_BITS   = 16;
	localparam int NUM_CH    = 6;
	localparam int LANE_MAX  = 64;
	localparam int CMD_MAX   = 16;
	localparam int CPL_W     = 7;
	localparam int SLOT_W    = 6;
	localparam int LE_W      = 5;
	localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int REM_W     = (BIT_W > 4) ? BIT_W : 4;

	localparam logic [CPL_W-1:0] CPL_RESET = CPL_W'(8);

	// one queued job: a data word or a latch command
	typedef struct packed {
		logic                            cmd;
		logic [NUM_CH-1:0][CH_BITS-1:0]  words;
		logic [LE_W-1:0]                 thr;
		logic [REM_W-1:0]                rem;
	} job_t;

endpackage

>>> sv/ldgs_if.sv
// ----------------------------------------------------------------------------
// ldgs_if
// Valid/ready channels: input items and serial clock results.
// ----------------------------------------------------------------------------
interface ldgs_item_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [ldgs_pkg::CH_BITS-1:0] red_top;
	logic [ldgs_pkg::CH_BITS-1:0] green_top;
	logic [ldgs_pkg::CH_BITS-1:0] blue_top;
	logic [ldgs_pkg::CH_BITS-1:0] red_bottom;
	logic [ldgs_pkg::CH_BITS-1:0] green_bottom;
	logic [ldgs_pkg::CH_BITS-1:0] blue_bottom;
	logic [ldgs_pkg::LE_W-1:0]    le_count;

	modport source (
		output valid, cmd, red_top, green_top, blue_top,
		       red_bottom, green_bottom, blue_bottom, le_count,
		input  ready
	);
	modport sink (
		input  valid, cmd, red_top, green_top, blue_top,
		       red_bottom, green_bottom, blue_bottom, le_count,
		output ready
	);
endinterface

interface ldgs_result_if;
	logic valid;
	logic ready;
	logic red_top_bit;
	logic green_top_bit;
	logic blue_top_bit;
	logic red_bottom_bit;
	logic green_bottom_bit;
	logic blue_bottom_bit;
	logic latch_enable;
	logic last;

	modport source (
		output valid, red_top_bit, green_top_bit, blue_top_bit,
		       red_bottom_bit, green_bottom_bit, blue_bottom_bit,
		       latch_enable, last,
		input  ready
	);
	modport sink (
		input  valid, red_top_bit, green_top_bit, blue_top_bit,
		       red_bottom_bit, green_bottom_bit, blue_bottom_bit,
		       latch_enable, last,
		output ready
	);
endinterface

>>> sv/ldgs_front.sv
// ----------------------------------------------------------------------------
// ldgs_front
// Accepts requests, tracks the chip slot and builds serializer jobs.
// ----------------------------------------------------------------------------
module ldgs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ldgs_pkg::CPL_W-1:0] cfg_wdata,
	ldgs_item_if.sink                  items,
	input  logic                       q_full,
	output logic                       push,
	output ldgs_pkg::job_t             push_job
);

	logic [ldgs_pkg::CPL_W-1:0]  cpl_q;
	logic [ldgs_pkg::SLOT_W-1:0] slot_q;
	logic [ldgs_pkg::SLOT_W-1:0] last_slot;
	logic [ldgs_pkg::LE_W-1:0]   cmd_clocks;
	logic                        accept;
	logic                        at_lane_end;

	assign items.ready = !q_full;
	assign accept      = items.valid && items.ready;

	always_comb begin
		if (cpl_q == '0) begin
			last_slot = '0;
		end else if (cpl_q > ldgs_pkg::CPL_W'(ldgs_pkg::LANE_MAX)) begin
			last_slot = ldgs_pkg::SLOT_W'(ldgs_pkg::LANE_MAX - 1);
		end else begin
			last_slot = ldgs_pkg::SLOT_W'(cpl_q - ldgs_pkg::CPL_W'(1));
		end
	end

	assign at_lane_end = (slot_q == last_slot);
	assign cmd_clocks  = (items.le_count > ldgs_pkg::LE_W'(ldgs_pkg::CMD_MAX)) ?
	                     ldgs_pkg::LE_W'(ldgs_pkg::CMD_MAX) : items.le_count;

	always_comb begin
		push_job = '0;
		push_job.cmd = items.cmd;
		if (items.cmd) begin
			push_job.rem = ldgs_pkg::REM_W'(cmd_clocks - ldgs_pkg::LE_W'(1));
			push = accept && (cmd_clocks != '0);
		end else begin
			push_job.words[0] = items.red_top;
			push_job.words[1] = items.green_top;
			push_job.words[2] = items.blue_top;
			push_job.words[3] = items.red_bottom;
			push_job.words[4] = items.green_bottom;
			push_job.words[5] = items.blue_bottom;
			push_job.thr      = at_lane_end ? items.le_count : '0;
			push_job.rem      = ldgs_pkg::REM_W'(ldgs_pkg::WORD_BITS - 1);
			push = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpl_q <= ldgs_pkg::CPL_RESET;
		end else if (cfg_we) begin
			cpl_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (accept) begin
			if (items.cmd || (slot_q >= last_slot)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + ldgs_pkg::SLOT_W'(1);
			end
		end
	end

endmodule

>>> sv/ldgs_queue.sv
// ----------------------------------------------------------------------------
// ldgs_queue
// Two-entry job queue between the front and the serializer.
// ----------------------------------------------------------------------------
module ldgs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ldgs_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output ldgs_pkg::job_t pop_job
);

	ldgs_pkg::job_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign pop_job = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> sv/ldgs_back.sv
// ----------------------------------------------------------------------------
// ldgs_back
// Serializer: steps a job one bit per clock into the result register, holding while the result is stalled.
// ----------------------------------------------------------------------------
module ldgs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  ldgs_pkg::job_t q_job,
	output logic           pop,
	ldgs_result_if.source  results
);

	ldgs_pkg::job_t              job_q;
	logic [ldgs_pkg::REM_W-1:0]  rem_q;
	logic                        busy_q;
	logic                        out_valid_q;
	logic [ldgs_pkg::NUM_CH-1:0] pins_q;
	logic                        le_q;
	logic                        last_q;
	logic                        can_load;
	logic                        emit;
	logic                        done;
	logic [ldgs_pkg::NUM_CH-1:0] pins;
	logic                        le;

	assign can_load = !out_valid_q || results.ready;
	assign emit     = busy_q && can_load;
	assign done     = (rem_q == '0);
	assign pop      = q_valid && (!busy_q || (emit && done));

	always_comb begin
		for (int c = 0; c < ldgs_pkg::NUM_CH; c++) begin
			pins[c] = !job_q.cmd && (32'(rem_q) < ldgs_pkg::CH_BITS) &&
			          job_q.words[c][rem_q[3:0]];
		end
		le = job_q.cmd || (32'(rem_q) < 32'(job_q.thr));
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (emit) begin
			pins_q <= pins;
			le_q   <= le;
			last_q <= done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				rem_q  <= q_job.rem;
			end else if (emit) begin
				if (done) begin
					busy_q <= 1'b0;
				end else begin
					rem_q <= rem_q - ldgs_pkg::REM_W'(1);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid            = out_valid_q;
	assign results.red_top_bit      = pins_q[0];
	assign results.green_top_bit    = pins_q[1];
	assign results.blue_top_bit     = pins_q[2];
	assign results.red_bottom_bit   = pins_q[3];
	assign results.green_bottom_bit = pins_q[4];
	assign results.blue_bottom_bit  = pins_q[5];
	assign results.latch_enable     = le_q;
	assign results.last             = last_q;

endmodule

>>> sv/led_driver_grayscale_serializer.sv
// Path: job queue, serializer job register, then the result register.
// A data word gives 16 results (one per serial bit), a command its latch
// clock count (at most 16), an empty command none; the serializer loads the
// next queued job on the cycle of the last bit.
// Reset: async active low clears the chip slot, queue and output register;
// chips_per_lane resets to 8.
// ----------------------------------------------------------------------------
// led_driver_grayscale_serializer
// Front classifier, two-entry job queue and bit serializer for one LED lane.
// ----------------------------------------------------------------------------
module led_driver_grayscale_serializer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ldgs_pkg::CPL_W-1:0] cfg_wdata,
	ldgs_item_if.sink                  items,
	ldgs_result_if.source              results
);

	logic           push;
	logic           q_full;
	logic           q_valid;
	logic           pop;
	ldgs_pkg::job_t push_job;
	ldgs_pkg::job_t pop_job;

	ldgs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.q_full    (q_full),
		.push      (push),
		.push_job  (push_job)
	);

	ldgs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.pop_job  (pop_job)
	);

	ldgs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_job   (pop_job),
		.pop     (pop),
		.results (results)
	);

endmodule

>>> test/ldgs_serial_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ldgs_serial_checker
// Watches the request and result channels and the lane size register. For
// each accepted request it predicts the serial clocks it causes. Each
// accepted result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module ldgs_serial_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [ldgs_pkg::CPL_W-1:0] cfg_wdata,
	ldgs_item_if                       items,
	ldgs_result_if                     results,
	output int                         mismatches,
	output int                         pending
);

	// pins[0] is red top, then green top, blue top, red bottom, green bottom, blue bottom
	typedef struct packed {
		logic [ldgs_pkg::NUM_CH-1:0] pins;
		logic                        latch_enable;
		logic                        last;
	} serial_clock_t;

	serial_clock_t                expected_clocks[$];
	logic [ldgs_pkg::CPL_W-1:0]   lane_chips = ldgs_pkg::CPL_RESET;
	logic [ldgs_pkg::SLOT_W-1:0]  chip_slot  = '0;

	function automatic int lane_size(input logic [ldgs_pkg::CPL_W-1:0] chips);
		if (chips == 0)
			return 1;
		if (chips > ldgs_pkg::LANE_MAX)
			return ldgs_pkg::LANE_MAX;
		return int'(chips);
	endfunction

	task automatic predict_serial_clocks(
		input logic                                               is_cmd,
		input logic [ldgs_pkg::NUM_CH-1:0][ldgs_pkg::CH_BITS-1:0] words,
		input logic [ldgs_pkg::LE_W-1:0]                          le
	);
		int            n_clocks;
		int            lanes;
		logic          on_last_chip;
		serial_clock_t sc;
		if (is_cmd) begin
			n_clocks = (le > ldgs_pkg::CMD_MAX) ? ldgs_pkg::CMD_MAX : int'(le);
			for (int k = 0; k < n_clocks; k++) begin
				sc.pins         = '0;
				sc.latch_enable = 1'b1;
				sc.last         = (k == n_clocks - 1);
				expected_clocks.push_back(sc);
			end
			chip_slot = '0;
		end else begin
			lanes        = lane_size(lane_chips);
			on_last_chip = (chip_slot == lanes - 1);
			for (int b = ldgs_pkg::WORD_BITS - 1; b >= 0; b--) begin
				for (int c = 0; c < ldgs_pkg::NUM_CH; c++)
					sc.pins[c] = (b < ldgs_pkg::CH_BITS) ? words[c][b] : 1'b0;
				sc.latch_enable = on_last_chip && (b < le);
				sc.last         = (b == 0);
				expected_clocks.push_back(sc);
			end
			if (chip_slot >= lanes - 1)
				chip_slot = '0;
			else
				chip_slot = chip_slot + ldgs_pkg::SLOT_W'(1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		serial_clock_t got;
		serial_clock_t want;
		if (!arst_n) begin
			lane_chips = ldgs_pkg::CPL_RESET;
			chip_slot  = '0;
			mismatches = 0;
			expected_clocks.delete();
		end else begin
			if (cfg_we)
				lane_chips = cfg_wdata;
			if (items.valid && items.ready)
				predict_serial_clocks(items.cmd,
					{items.blue_bottom, items.green_bottom, items.red_bottom,
					 items.blue_top, items.green_top, items.red_top},
					items.le_count);
			if (results.valid && results.ready) begin
				got.pins = {results.blue_bottom_bit, results.green_bottom_bit,
					results.red_bottom_bit, results.blue_top_bit,
					results.green_top_bit, results.red_top_bit};
				got.latch_enable = results.latch_enable;
				got.last         = results.last;
				if (expected_clocks.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected serial clock pins=%b le=%b last=%b",
							$realtime, got.pins, got.latch_enable, got.last);
					mismatches++;
				end else begin
					want = expected_clocks.pop_front();
					if (got !== want) begin
						if (mismatches < 10)
							$display(
"%0t: clock mismatch: pins exp %b got %b, le exp %b got %b, last exp %b got %b",
								$realtime, want.pins, got.pins,
								want.latch_enable, got.latch_enable,
								want.last, got.last);
						mismatches++;
					end
				end
			end
		end
		pending = expected_clocks.size();
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives data words and latch commands into the LED lane serializer under
// several lane sizes, with random gaps on the request side and random stalls
// on the result side; the serial checker predicts and compares every clock.
// ----------------------------------------------------------------------------
module testbench;

	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int NUM_PHASES   = 6;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_we;
	logic [ldgs_pkg::CPL_W-1:0] cfg_wdata;
	bit                         steady = 1'b0;
	int                         quiet_cycles = 0;
	int                         mismatches;
	int                         pending;

	ldgs_item_if   items ();
	ldgs_result_if results ();

	led_driver_grayscale_serializer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.items     (items),
		.results   (results)
	);

	ldgs_serial_checker serial_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.items      (items),
		.results    (results),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ldgs_pkg::CH_BITS-1:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return ldgs_pkg::CH_BITS'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	function automatic logic [ldgs_pkg::LE_W-1:0] pick_le();
		if ($urandom_range(0, 3) == 0)
			return ldgs_pkg::LE_W'($urandom_range(0, 31));
		return ldgs_pkg::LE_W'($urandom_range(0, ldgs_pkg::WORD_BITS));
	endfunction

	task automatic send_request(
		input logic                                               is_cmd,
		input logic [ldgs_pkg::NUM_CH-1:0][ldgs_pkg::CH_BITS-1:0] words,
		input logic [ldgs_pkg::LE_W-1:0]                          le
	);
		int gap;
		items.valid        <= 1'b1;
		items.cmd          <= is_cmd;
		items.red_top      <= words[0];
		items.green_top    <= words[1];
		items.blue_top     <= words[2];
		items.red_bottom   <= words[3];
		items.green_bottom <= words[4];
		items.blue_bottom  <= words[5];
		items.le_count     <= le;
		do @(posedge clk); while (!items.ready);
		gap = pick_gap();
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_request(input int cmd_pct);
		logic [ldgs_pkg::NUM_CH-1:0][ldgs_pkg::CH_BITS-1:0] words;
		for (int c = 0; c < ldgs_pkg::NUM_CH; c++)
			words[c] = pick_word();
		send_request($urandom_range(0, 99) < cmd_pct, words, pick_le());
	endtask

	task automatic drain_requests();
		items.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_lane_size(input logic [ldgs_pkg::CPL_W-1:0] chips);
		cfg_we    <= 1'b1;
		cfg_wdata <= chips;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// result side: random stalls
	initial begin : result_sink
		int stall;
		stall = 0;
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall == 0 && $urandom_range(0, 2) == 0)
				stall = pick_gap();
			if (stall > 0) begin
				results.ready <= 1'b0;
				stall--;
			end else begin
				results.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((items.valid && items.ready) || (results.valid && results.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		logic [ldgs_pkg::NUM_CH-1:0][ldgs_pkg::CH_BITS-1:0] w;
		int lane_settings [NUM_PHASES];
		int phase_items   [NUM_PHASES];
		int cmd_pct;
		int le_sel;
		lane_settings = '{1, 0, 127, 3, 64, 16};
		phase_items   = '{40, 40, 70, 50, 70, 40};

		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= '0;
		items.valid        <= 1'b0;
		items.cmd          <= 1'b0;
		items.red_top      <= '0;
		items.green_top    <= '0;
		items.blue_top     <= '0;
		items.red_bottom   <= '0;
		items.green_bottom <= '0;
		items.blue_bottom  <= '0;
		items.le_count     <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full lane at reset size: zeros, all ones, bit patterns, last chip full tail
		for (int i = 0; i < 8; i++) begin
			case (i)
				0: w = '0;
				1: w = '1;
				2: w = {16'h00FF, 16'hFF00, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000};
				default:
					for (int c = 0; c < ldgs_pkg::NUM_CH; c++)
						w[c] = pick_word();
			endcase
			le_sel = (i == 0) ? 0 : (i == 2) ? 31 : (i == 7) ? 16 :
				(i == 1) ? 16 : int'(pick_le());
			send_request(1'b0, w, ldgs_pkg::LE_W'(le_sel));
		end
		// latch commands: empty, single, full, clipped
		w = '1;
		send_request(1'b1, w, ldgs_pkg::LE_W'(0));
		send_request(1'b1, w, ldgs_pkg::LE_W'(1));
		send_request(1'b1, w, ldgs_pkg::LE_W'(16));
		send_request(1'b1, w, ldgs_pkg::LE_W'(31));
		// command in mid lane returns to the first chip
		for (int i = 0; i < 3; i++) begin
			w = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
			send_request(1'b0, w, pick_le());
		end
		send_request(1'b1, w, ldgs_pkg::LE_W'(2));
		for (int i = 0; i < 8; i++) begin
			w = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
			send_request(1'b0, w, (i == 7) ? ldgs_pkg::LE_W'(1) : pick_le());
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_requests();
			write_lane_size(ldgs_pkg::CPL_W'(lane_settings[p]));
			cmd_pct = (lane_settings[p] >= ldgs_pkg::LANE_MAX) ? 0 : 15;
			for (int i = 0; i < phase_items[p]; i++) begin
				if (i % 25 == 0)
					steady = ($urandom_range(0, 3) == 0);
				send_random_request(cmd_pct);
			end
			steady = 1'b0;
		end

		drain_requests();
		if (mismatches == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
sv/ldgs_pkg.sv
sv/ldgs_if.sv
sv/ldgs_front.sv
sv/ldgs_queue.sv
sv/ldgs_back.sv
sv/led_driver_grayscale_serializer.sv
test/ldgs_serial_checker.sv
test/testbench.sv
